[sv/dcc_command_packet_assembler_unit_assert.svh]
// ----------------------------------------------------------------------------
// DCC packet assembler assertion macros
// Shared property forms for the concurrent checks of the assembler.
// ----------------------------------------------------------------------------
`ifndef DCC_COMMAND_PACKET_ASSEMBLER_UNIT_ASSERT_SVH
`define DCC_COMMAND_PACKET_ASSEMBLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("DCC assembler check failed");

// The consequent must hold in the cycle after the antecedent.
`define DCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("DCC assembler check failed");

`endif

[sv/dcc_cpa_pkg.sv]
// ----------------------------------------------------------------------------
// DCC packet assembler package
// Request codes, packet constants and the packet buffer type.
// ----------------------------------------------------------------------------
package dcc_cpa_pkg;

    localparam int PKT_BYTES = 4;
    localparam int LEN_W     = 3;

    typedef enum logic [2:0] {
        REQ_SPEED     = 3'd0,
        REQ_FUNC_GRP  = 3'd1,
        REQ_FUNC_EXP  = 3'd2,
        REQ_CV_WRITE  = 3'd3,
        REQ_CV_VERIFY = 3'd4,
        REQ_IDLE      = 3'd5
    } t_req_type;

    localparam logic [1:0] GRP_LOW = 2'd0;
    localparam logic [1:0] GRP_MID = 2'd1;

    localparam logic [7:0] SPEED_128_INSTR = 8'b0011_1111;
    localparam logic [7:0] FG_F0_BASE      = 8'b1000_0000;
    localparam logic [7:0] FG_F5_BASE      = 8'b1011_0000;
    localparam logic [7:0] FG_F9_BASE      = 8'b1010_0000;
    localparam logic [7:0] FX_F13_INSTR    = 8'b1101_1110;
    localparam logic [7:0] FX_F21_INSTR    = 8'b1101_1111;
    localparam logic [7:0] FX_F29_INSTR    = 8'b1101_1000;
    localparam logic [7:0] CV_WRITE_BASE   = 8'h7C;
    localparam logic [7:0] CV_VERIFY_BASE  = 8'b0111_1000;
    localparam logic [7:0] CV_BIT_BASE     = 8'b1110_1000;
    localparam logic [7:0] IDLE_BYTE0      = 8'hFF;
    localparam logic [7:0] IDLE_BYTE1      = 8'h00;

    typedef struct packed {
        logic [PKT_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
    } t_pkt;

endpackage

[sv/dcc_cpa_build.sv]
// ----------------------------------------------------------------------------
// DCC packet builder
// Forms all bytes of one packet, including the checksum, from a request.
// ----------------------------------------------------------------------------
module dcc_cpa_build
    import dcc_cpa_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 4
) (
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_loco_address,
    input  logic [6:0]  i_speed_step,
    input  logic        i_forward,
    input  logic [7:0]  i_function_bits,
    input  logic [1:0]  i_group,
    input  logic [10:0] i_cv_number,
    input  logic [7:0]  i_cv_value,
    input  logic [2:0]  i_bit_position,
    output t_pkt        o_pkt
);

    logic [9:0]                cva;
    logic [PKT_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
    logic [7:0]                chk;

    always_comb begin
        cva   = i_cv_number[9:0] - 10'd1;
        bytes = '0;
        len   = '0;
        case (i_req_type)
            REQ_SPEED: begin
                bytes[0] = i_loco_address;
                bytes[1] = SPEED_128_INSTR;
                bytes[2] = {i_forward, i_speed_step};
                len      = LEN_W'(3);
            end
            REQ_FUNC_GRP: begin
                bytes[0] = i_loco_address;
                case (i_group)
                    GRP_LOW: bytes[1] = FG_F0_BASE | {3'b000, i_function_bits[4:0]};
                    GRP_MID: bytes[1] = FG_F5_BASE | {4'b0000, i_function_bits[3:0]};
                    default: bytes[1] = FG_F9_BASE | {4'b0000, i_function_bits[3:0]};
                endcase
                len = LEN_W'(2);
            end
            REQ_FUNC_EXP: begin
                bytes[0] = i_loco_address;
                case (i_group)
                    GRP_LOW: bytes[1] = FX_F13_INSTR;
                    GRP_MID: bytes[1] = FX_F21_INSTR;
                    default: bytes[1] = FX_F29_INSTR;
                endcase
                bytes[2] = i_function_bits;
                len      = LEN_W'(3);
            end
            REQ_CV_WRITE: begin
                bytes[0] = CV_WRITE_BASE | {6'b000000, cva[9:8]};
                bytes[1] = cva[7:0];
                bytes[2] = i_cv_value;
                len      = LEN_W'(3);
            end
            REQ_CV_VERIFY: begin
                bytes[0] = CV_VERIFY_BASE | {6'b000000, cva[9:8]};
                bytes[1] = cva[7:0];
                bytes[2] = CV_BIT_BASE | {5'b00000, i_bit_position};
                len      = LEN_W'(3);
            end
            REQ_IDLE: begin
                bytes[0] = IDLE_BYTE0;
                bytes[1] = IDLE_BYTE1;
                len      = LEN_W'(2);
            end
            default: begin
                len = '0;
            end
        endcase
        chk = bytes[0] ^ bytes[1] ^ bytes[2];
        if (len != '0) begin
            bytes[len[1:0]] = chk;
            len             = len + LEN_W'(1);
        end
        if (int'(len) > MAX_PACKET_BYTES) begin
            len = '0;
        end
        o_pkt.bytes = bytes;
        o_pkt.len   = len;
    end

endmodule

[sv/dcc_cpa_ser.sv]
// ----------------------------------------------------------------------------
// DCC packet serializer
// Holds one built packet and sends it out one registered byte per cycle.
// ----------------------------------------------------------------------------
module dcc_cpa_ser
    import dcc_cpa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_pkt       i_pkt,
    output logic       o_busy,
    output logic       o_strobe,
    output logic [7:0] o_packet_byte,
    output logic [1:0] o_byte_index,
    output logic       o_last
);

    logic [PKT_BYTES-1:0][7:0] r_bytes;
    logic [LEN_W-1:0]          r_len;
    logic [1:0]                r_pos;
    logic                      r_act;
    logic                      n_act;
    logic                      r_strobe;
    logic [7:0]                r_byte;
    logic [1:0]                r_idx;
    logic                      r_last;
    logic                      w_last_emit;
    logic                      w_load;

    assign w_last_emit = r_act && ({1'b0, r_pos} == r_len - LEN_W'(1));
    assign o_busy      = r_act && !w_last_emit;
    assign w_load      = i_start && !o_busy && (i_pkt.len != '0);

    always_comb begin
        n_act = r_act;
        if (w_last_emit) begin
            n_act = 1'b0;
        end
        if (w_load) begin
            n_act = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_act    <= n_act;
            r_strobe <= r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bytes <= i_pkt.bytes;
            r_len   <= i_pkt.len;
            r_pos   <= 2'd0;
        end else if (r_act) begin
            r_pos <= r_pos + 2'd1;
        end
        r_byte <= r_bytes[r_pos];
        r_idx  <= r_pos;
        r_last <= w_last_emit;
    end

    assign o_strobe      = r_strobe;
    assign o_packet_byte = r_byte;
    assign o_byte_index  = r_idx;
    assign o_last        = r_last;

`include "dcc_command_packet_assembler_unit_assert.svh"

    `DCC_ASSERT_NEXT(a_last_marked, w_last_emit, o_strobe && o_last)
    `DCC_ASSERT_NEXT(a_index_steps, o_strobe && !o_last,
                     o_strobe && (o_byte_index == $past(o_byte_index) + 2'd1))
    `DCC_ASSERT_SAME(a_packet_min_len, o_strobe && o_last, o_byte_index >= 2'd2)
    `DCC_ASSERT_SAME(a_busy_mid_packet, r_act && !w_last_emit, o_busy)

endmodule

[sv/dcc_command_packet_assembler_unit.sv]
// ----------------------------------------------------------------------------
// DCC command packet assembler
// A request sets the active flag, after which the first byte is strobed.
// Throughput: one byte per cycle; a packet is 3 or 4 bytes long, and the next
// request is taken while the last byte of the current one is read out.
// Reset: synchronous, active low; clears busy and the result strobe.
// ----------------------------------------------------------------------------
module dcc_command_packet_assembler_unit
    import dcc_cpa_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_loco_address,
    input  logic [6:0]  i_speed_step,
    input  logic        i_forward,
    input  logic [7:0]  i_function_bits,
    input  logic [1:0]  i_group,
    input  logic [10:0] i_cv_number,
    input  logic [7:0]  i_cv_value,
    input  logic [2:0]  i_bit_position,
    output logic        o_strobe,
    output logic [7:0]  o_packet_byte,
    output logic [1:0]  o_byte_index,
    output logic        o_last
);

    t_pkt w_pkt;

    dcc_cpa_build #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_build (
        .i_req_type     (i_req_type),
        .i_loco_address (i_loco_address),
        .i_speed_step   (i_speed_step),
        .i_forward      (i_forward),
        .i_function_bits(i_function_bits),
        .i_group        (i_group),
        .i_cv_number    (i_cv_number),
        .i_cv_value     (i_cv_value),
        .i_bit_position (i_bit_position),
        .o_pkt          (w_pkt)
    );

    dcc_cpa_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_pkt        (w_pkt),
        .o_busy       (busy),
        .o_strobe     (o_strobe),
        .o_packet_byte(o_packet_byte),
        .o_byte_index (o_byte_index),
        .o_last       (o_last)
    );

endmodule
